// File: rtl/core/fvc_pkg.sv
// Shared types and codes for the flow verdict cache.
// Used by fvc_judge and flow_verdict_cache_top; no dependencies.
`default_nettype none

package fvc_pkg;

	// Flow table geometry: one memory row per flow, both slots side by side
	localparam int FLOW_ENTRIES = 1024;
	localparam int ROW_W        = $clog2(FLOW_ENTRIES);
	localparam int FLOW_IDX_W   = 10;
	localparam int GEN_W        = 32;
	localparam int TIME_W       = 32;
	localparam int HASH_W       = 64;

	// Input stream packing
	localparam int IN_DATA_W = 152;
	localparam int OUT_DATA_W = 8;

	// Actions
	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	// Evaluator status
	localparam logic [1:0] EVS_JUDGED    = 2'd0;
	localparam logic [1:0] EVS_NO_POLICY = 2'd1;

	// Verdicts
	localparam logic [1:0] VRD_PASS   = 2'd0;
	localparam logic [1:0] VRD_REJECT = 2'd1;

	// Dispositions
	localparam logic [1:0] DISP_ACCEPT = 2'd0;
	localparam logic [1:0] DISP_DROP   = 2'd1;
	localparam logic [1:0] DISP_REFUSE = 2'd2;

	// Lookup outcomes
	localparam logic [2:0] OUTC_UNTRACKED   = 3'd0;
	localparam logic [2:0] OUTC_HIT         = 3'd1;
	localparam logic [2:0] OUTC_EMPTY       = 3'd2;
	localparam logic [2:0] OUTC_STALE       = 3'd3;
	localparam logic [2:0] OUTC_EXPIRED     = 3'd4;
	localparam logic [2:0] OUTC_PERMISSIVE  = 3'd5;
	localparam logic [2:0] OUTC_FAIL_CLOSED = 3'd6;
	localparam logic [2:0] OUTC_UNCACHED    = 3'd7;

	// One cached sentence
	typedef struct packed {
		logic [GEN_W-1:0]  generation;
		logic [TIME_W-1:0] expiry;
		logic [1:0]        verdict;
		logic [1:0]        rej_kind;
	} slot_t;

	// One memory row: both slots of a flow
	typedef struct packed {
		slot_t s1;
		slot_t s0;
	} row_t;

	localparam int ROW_BITS = $bits(row_t);

	// Latched request fields used by the decision logic
	typedef struct packed {
		logic                  action;
		logic [FLOW_IDX_W-1:0] flow_index;
		logic                  untracked;
		logic                  cacheable;
		logic                  loopback;
		logic                  direction_in;
		logic [TIME_W-1:0]     now_secs;
		logic [1:0]            eval_status;
		logic [1:0]            eval_verdict;
		logic [1:0]            eval_rej_kind;
		logic [TIME_W-1:0]     eval_expires_at;
	} item_t;

	// Result item, disposition in the lowest bits
	typedef struct packed {
		logic       evaluation_used;
		logic [2:0] lookup_outcome;
		logic [1:0] refusal_kind;
		logic [1:0] disposition;
	} result_t;

	// Control sequencer
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} state_t;

endpackage

`default_nettype wire

// File: rtl/core/fvc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module fvc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/core/fvc_judge.sv
// Decision logic: judges one request against the flow's slot pair and
// builds the row to write back. Depends on fvc_pkg.
`default_nettype none

module fvc_judge
	import fvc_pkg::*;
(
	input  wire item_t             item,
	input  wire row_t              row,
	input  wire logic [GEN_W-1:0]  cur_gen,
	output result_t                res,
	output logic                   wr_en,
	output row_t                   wr_row
);

	// true when verdict/kind pair a is stricter than pair b
	function automatic logic stricter(logic [1:0] va, logic [1:0] ka,
	                                  logic [1:0] vb, logic [1:0] kb);
		logic r;
		if (va != vb) begin
			r = (va > vb);
		end else begin
			r = (va == VRD_REJECT) && (ka < kb);
		end
		return r;
	endfunction

	logic       sel;
	slot_t      cur;
	slot_t      oth;
	slot_t      fresh;
	logic       cur_expired;
	logic       oth_current;
	logic [2:0] outc;
	logic [1:0] v;
	logic [1:0] k;
	logic       go_merge;

	always_comb begin
		sel   = item.loopback & item.direction_in;
		cur   = sel ? row.s1 : row.s0;
		oth   = sel ? row.s0 : row.s1;
		cur_expired = (cur.expiry != '0) && (item.now_secs >= cur.expiry);
		oth_current = (oth.generation != '0) && (oth.generation == cur_gen) &&
		              !((oth.expiry != '0) && (item.now_secs >= oth.expiry));
		fresh = '{generation: cur_gen, expiry: item.eval_expires_at,
		          verdict: item.eval_verdict, rej_kind: item.eval_rej_kind};

		res      = '0;
		wr_en    = 1'b0;
		wr_row   = row;
		outc     = OUTC_UNTRACKED;
		v        = VRD_PASS;
		k        = '0;
		go_merge = 1'b0;

		if (item.action == ACT_CLEAR) begin
			// empty both slots of the flow
			wr_en                = 1'b1;
			wr_row.s0.generation = '0;
			wr_row.s1.generation = '0;
		end else if (!item.untracked) begin
			// classify the selected slot
			if (!item.cacheable) begin
				outc = OUTC_UNCACHED;
			end else if (cur.generation == '0) begin
				outc = OUTC_EMPTY;
			end else if (cur.generation != cur_gen) begin
				outc = OUTC_STALE;
			end else if (cur_expired) begin
				outc = OUTC_EXPIRED;
			end else begin
				outc = OUTC_HIT;
			end

			if (outc == OUTC_HIT) begin
				v        = cur.verdict;
				k        = cur.rej_kind;
				go_merge = 1'b1;
			end else if (item.eval_status == EVS_NO_POLICY) begin
				res = '{evaluation_used: 1'b1, lookup_outcome: OUTC_PERMISSIVE,
				        refusal_kind: 2'd0, disposition: DISP_ACCEPT};
			end else if (item.eval_status != EVS_JUDGED) begin
				// evaluator error fails closed
				res = '{evaluation_used: 1'b1, lookup_outcome: OUTC_FAIL_CLOSED,
				        refusal_kind: 2'd0, disposition: DISP_DROP};
			end else begin
				v = item.eval_verdict;
				k = item.eval_rej_kind;
				if (item.cacheable) begin
					wr_en = 1'b1;
					if (sel) begin
						wr_row.s1 = fresh;
					end else begin
						wr_row.s0 = fresh;
					end
				end
				if (v == VRD_REJECT) begin
					res = '{evaluation_used: 1'b1, lookup_outcome: outc,
					        refusal_kind: k, disposition: DISP_REFUSE};
				end else begin
					go_merge = 1'b1;
				end
			end

			// loopback flows answer to the stricter current sentence
			if (go_merge) begin
				if (item.loopback && item.cacheable && oth_current &&
				    stricter(oth.verdict, oth.rej_kind, v, k)) begin
					v = oth.verdict;
					k = oth.rej_kind;
				end
				res.evaluation_used = (outc != OUTC_HIT);
				res.lookup_outcome  = outc;
				if (v == VRD_PASS) begin
					res.disposition  = DISP_ACCEPT;
					res.refusal_kind = 2'd0;
				end else if (v == VRD_REJECT) begin
					res.disposition  = DISP_REFUSE;
					res.refusal_kind = k;
				end else begin
					res.disposition  = DISP_DROP;
					res.refusal_kind = 2'd0;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/flow_verdict_cache_top.sv
// Flow verdict cache top level: request sequencer, slot memory, output register.
// Depends on fvc_pkg, fvc_ram and fvc_judge.
//
// Each request is accepted in ST_IDLE, which issues the read of the flow's row
// (both slots, one memory word); ST_LOOKUP then judges it and writes the row
// back, holding while the output register is full, then returns to ST_IDLE.
// Results sit in an output register, so the next request is taken while a
// result still waits. After reset a clearing pass writes every flow row empty,
// one row per cycle, all FLOW_ENTRIES (1024) rows, before the first request is
// taken; configuration writes are accepted throughout.
`default_nettype none

module flow_verdict_cache_top
	import fvc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config: current_generation
	input  wire logic                  cfg_we,
	input  wire logic [GEN_W-1:0]      cfg_wdata,
	// request stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// s_tdata from bit 0: flow_index[9:0], untracked, cacheable, loopback,
	// direction_in, now_secs[31:0], eval_status[1:0], eval_verdict[1:0],
	// eval_rej_kind[1:0], eval_expires_at[31:0], eval_rule_hash[63:0], zero pad
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: action
	input  wire logic                  s_tuser,
	// result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// m_tdata from bit 0: disposition[1:0], refusal_kind[1:0],
	// lookup_outcome[2:0], evaluation_used
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	state_t              state_q, state_d;
	logic [ROW_W-1:0]    clr_q;
	logic [GEN_W-1:0]    gen_q;
	item_t               item_q;
	logic                m_valid_q;
	result_t             m_data_q;

	item_t               in_item;
	row_t                rd_row;
	logic [ROW_BITS-1:0] rd_bits;
	result_t             res;
	logic                j_wr_en;
	row_t                j_wr_row;
	logic                out_free;
	logic                accept;
	logic                finish;
	logic                ram_we;
	logic [ROW_W-1:0]    ram_waddr;
	logic [ROW_BITS-1:0] ram_wdata;
	logic [ROW_W-1:0]    ram_raddr;

	// unpack the request
	assign in_item = '{
		action:           s_tuser,
		flow_index:       s_tdata[9:0],
		untracked:        s_tdata[10],
		cacheable:        s_tdata[11],
		loopback:         s_tdata[12],
		direction_in:     s_tdata[13],
		now_secs:         s_tdata[45:14],
		eval_status:      s_tdata[47:46],
		eval_verdict:     s_tdata[49:48],
		eval_rej_kind:    s_tdata[51:50],
		eval_expires_at:  s_tdata[83:52]
	};

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign finish   = (state_q == ST_LOOKUP) && out_free;

	// generation register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= GEN_W'(1);
		end else if (cfg_we) begin
			gen_q <= cfg_wdata;
		end
	end

	// sequencer state and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + ROW_W'(1);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ROW_W'(FLOW_ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// latched request
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
	end

	// slot memory: read at the incoming flow, hold the address while judging
	assign ram_raddr = (state_q == ST_LOOKUP) ? item_q.flow_index[ROW_W-1:0]
	                                           : in_item.flow_index[ROW_W-1:0];
	assign ram_we    = (state_q == ST_CLEAR) || (finish && j_wr_en);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : item_q.flow_index[ROW_W-1:0];
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : ROW_BITS'(j_wr_row);
	assign rd_row    = row_t'(rd_bits);

	fvc_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (FLOW_ENTRIES)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_bits)
	);

	fvc_judge u_judge (
		.item    (item_q),
		.row     (rd_row),
		.cur_gen (gen_q),
		.res     (res),
		.wr_en   (j_wr_en),
		.wr_row  (j_wr_row)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (finish) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			m_data_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'(m_data_q);

endmodule

`default_nettype wire
